>>> rtl/core/wss_pkg.sv
// Shared constants, types and register codes for the window sample statistics block.
package wss_pkg;

  localparam int MAX_SAMPLES = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_W      = 32;
  localparam int CH_W        = 8;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int SQ_W   = 2 * SAMPLE_BITS - 2 + CNT_W;
  localparam int MSQ_W  = 2 * SAMPLE_BITS - 1;
  localparam int RT_W   = SAMPLE_BITS;
  localparam int STEP_W = $clog2(SQ_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QSUM_W = QCNT_W + 1;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIN_BEGIN = 2'd0,
    CFG_WIN_END   = 2'd1,
    CFG_CHANNEL   = 2'd2
  } cfg_idx_t;

  // Finished record handed from the front to the back.
  typedef struct packed {
    logic [CNT_W-1:0]              count;
    logic signed [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]               sq;
    logic signed [SAMPLE_BITS-1:0] min_v;
    logic signed [SAMPLE_BITS-1:0] max_v;
    logic [TIME_W-1:0]             first_t;
    logic [TIME_W-1:0]             last_t;
    logic                          ovf;
    logic [CH_W-1:0]               ch;
  } rec_t;

  typedef struct packed {
    logic push;
    rec_t rec;
  } q_wr_t;

endpackage

>>> rtl/core/wss_stream_if.sv
// Sample and result stream interfaces with valid/ready handshake.
interface wss_in_if;
  import wss_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [TIME_W-1:0]             sample_time;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          last_sample;

  modport source (output valid, sample_time, sample_value, last_sample, input ready);
  modport sink   (input valid, sample_time, sample_value, last_sample, output ready);
endinterface

interface wss_out_if;
  import wss_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          valid_res;
  logic [CH_W-1:0]               channel_echo;
  logic [CNT_W-1:0]              sample_count;
  logic signed [SAMPLE_BITS-1:0] min_value;
  logic signed [SAMPLE_BITS-1:0] max_value;
  logic [SAMPLE_BITS-1:0]        peak_to_peak;
  logic [TIME_W-1:0]             duration;
  logic signed [SAMPLE_BITS-1:0] mean_value;
  logic [RT_W-1:0]               rms_value;
  logic                          overflow;

  modport source (output valid, valid_res, channel_echo, sample_count, min_value, max_value,
                  peak_to_peak, duration, mean_value, rms_value, overflow, input ready);
  modport sink   (input valid, valid_res, channel_echo, sample_count, min_value, max_value,
                  peak_to_peak, duration, mean_value, rms_value, overflow, output ready);
endinterface

>>> rtl/core/wss_front.sv
// Front end: window test, square, and per-record accumulation of samples.
module wss_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [wss_pkg::TIME_W-1:0]    win_begin,
  input  logic [wss_pkg::TIME_W-1:0]    win_end,
  input  logic [wss_pkg::CH_W-1:0]      chan,
  input  logic [wss_pkg::QCNT_W-1:0]    q_count,
  output wss_pkg::q_wr_t                q_wr,
  wss_in_if.sink                        in_ch
);
  import wss_pkg::*;

  logic [TIME_W-1:0]             lo;
  logic [TIME_W-1:0]             hi;
  logic                          in_win;
  logic                          pend;
  logic                          acc;
  logic signed [2*SAMPLE_BITS-1:0] prod;

  logic                          s1_valid_r;
  logic                          s1_valid_nxt;
  logic                          s1_last_r;
  logic                          s1_inwin_r;
  logic [TIME_W-1:0]             s1_time_r;
  logic signed [SAMPLE_BITS-1:0] s1_value_r;
  logic [MSQ_W-1:0]              s1_sq_r;

  logic [CNT_W-1:0]              cnt_r, cnt_nxt, cnt_u;
  logic signed [SUM_W-1:0]       sum_r, sum_nxt, sum_u;
  logic [SQ_W-1:0]               sq_r, sq_nxt, sq_u;
  logic signed [SAMPLE_BITS-1:0] min_r, min_nxt, min_u;
  logic signed [SAMPLE_BITS-1:0] max_r, max_nxt, max_u;
  logic [TIME_W-1:0]             first_r, first_nxt, first_u;
  logic [TIME_W-1:0]             last_r, last_nxt, last_u;
  logic                          ovf_r, ovf_nxt, ovf_u;
  logic                          full;
  logic                          take;
  logic                          close;

  // Order the window bounds and test the incoming word against them.
  always_comb begin
    if (win_begin > win_end) begin
      lo = win_end;
      hi = win_begin;
    end else begin
      lo = win_begin;
      hi = win_end;
    end
    in_win = (in_ch.sample_time >= lo) && (in_ch.sample_time <= hi);
  end

  // Hold off while the queue has no slot for a record end still in flight.
  assign pend        = s1_valid_r && s1_last_r;
  assign in_ch.ready = (QSUM_W'(q_count) + QSUM_W'(pend)) < QSUM_W'(QDEPTH);
  assign acc         = in_ch.valid && in_ch.ready;
  assign prod        = in_ch.sample_value * in_ch.sample_value;
  assign s1_valid_nxt = acc;

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_last_r  <= in_ch.last_sample;
      s1_inwin_r <= in_win;
      s1_time_r  <= in_ch.sample_time;
      s1_value_r <= in_ch.sample_value;
      s1_sq_r    <= prod[MSQ_W-1:0];
    end
  end

  always_comb begin
    full  = (cnt_r == CNT_W'(MAX_SAMPLES));
    take  = s1_valid_r && s1_inwin_r && !full;
    close = s1_valid_r && s1_last_r;

    cnt_u   = take ? cnt_r + 1'b1 : cnt_r;
    sum_u   = take ? sum_r + SUM_W'(s1_value_r) : sum_r;
    sq_u    = take ? sq_r + SQ_W'(s1_sq_r) : sq_r;
    min_u   = (take && (s1_value_r < min_r)) ? s1_value_r : min_r;
    max_u   = (take && (s1_value_r > max_r)) ? s1_value_r : max_r;
    first_u = (take && (cnt_r == '0)) ? s1_time_r : first_r;
    last_u  = take ? s1_time_r : last_r;
    ovf_u   = ovf_r || (s1_valid_r && s1_inwin_r && full);

    q_wr.push        = close;
    q_wr.rec.count   = cnt_u;
    q_wr.rec.sum     = sum_u;
    q_wr.rec.sq      = sq_u;
    q_wr.rec.min_v   = min_u;
    q_wr.rec.max_v   = max_u;
    q_wr.rec.first_t = first_u;
    q_wr.rec.last_t  = last_u;
    q_wr.rec.ovf     = ovf_u;
    q_wr.rec.ch      = chan;

    // Clear after the record end has been handed over.
    if (close) begin
      cnt_nxt   = '0;
      sum_nxt   = '0;
      sq_nxt    = '0;
      min_nxt   = SAMPLE_MAX;
      max_nxt   = SAMPLE_MIN;
      first_nxt = '0;
      last_nxt  = '0;
      ovf_nxt   = 1'b0;
    end else begin
      cnt_nxt   = cnt_u;
      sum_nxt   = sum_u;
      sq_nxt    = sq_u;
      min_nxt   = min_u;
      max_nxt   = max_u;
      first_nxt = first_u;
      last_nxt  = last_u;
      ovf_nxt   = ovf_u;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      cnt_r      <= '0;
      sum_r      <= '0;
      sq_r       <= '0;
      min_r      <= SAMPLE_MAX;
      max_r      <= SAMPLE_MIN;
      first_r    <= '0;
      last_r     <= '0;
      ovf_r      <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      sq_r       <= sq_nxt;
      min_r      <= min_nxt;
      max_r      <= max_nxt;
      first_r    <= first_nxt;
      last_r     <= last_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

  a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    close |=> (cnt_r == '0) && !ovf_r)
    else $error("accumulators not cleared after record end");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SAMPLES))
    else $error("sample count above capacity");

endmodule

>>> rtl/core/wss_queue.sv
// Short record queue between the accumulating front and the arithmetic back.
module wss_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  wss_pkg::q_wr_t             q_wr,
  input  logic                       pop,
  output logic                       q_valid,
  output wss_pkg::rec_t              q_head,
  output logic [wss_pkg::QCNT_W-1:0] q_count
);
  import wss_pkg::*;

  rec_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_pop;

  assign q_valid = (count_r != '0);
  assign q_head  = mem_r[rd_ptr_r];
  assign q_count = count_r;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (q_wr.push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + QCNT_W'(q_wr.push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      mem_r[wr_ptr_r] <= q_wr.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.push |-> (count_r != QCNT_W'(QDEPTH)))
    else $error("record pushed into full queue");

endmodule

>>> rtl/core/wss_back.sv
// Back end: bit-serial divides, bit-serial square root and the result register.
module wss_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  wss_pkg::rec_t q_head,
  output logic          q_pop,
  wss_out_if.source     out_ch
);
  import wss_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_ROOT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  rec_t               rec_r;
  logic [STEP_W-1:0]  step_r;
  logic [SQ_W-1:0]    dvd_a_r, dvd_a_nxt;
  logic [SQ_W-1:0]    dvd_b_r, dvd_b_nxt;
  logic [CNT_W:0]     rem_a_r, rem_a_nxt, rem_a_t;
  logic [CNT_W:0]     rem_b_r, rem_b_nxt, rem_b_t;
  logic               ge_a, ge_b;
  logic [2*RT_W-1:0]  rad_r;
  logic [RT_W-1:0]    root_r, root_nxt;
  logic [RT_W:0]      rrem_r;
  logic [RT_W+2:0]    rr_t, trial, rrem_full;
  logic               ge_r;
  logic [SUM_W-1:0]   sum_mag;
  logic               div_end, root_end;
  logic               load;
  logic               has;
  logic [SAMPLE_BITS-1:0] q_mean, mean_val;

  logic                          out_valid_r, out_valid_nxt;
  logic                          o_res_r;
  logic [CH_W-1:0]               o_ch_r;
  logic [CNT_W-1:0]              o_cnt_r;
  logic signed [SAMPLE_BITS-1:0] o_min_r, o_max_r, o_mean_r;
  logic [SAMPLE_BITS-1:0]        o_p2p_r;
  logic [TIME_W-1:0]             o_dur_r;
  logic [RT_W-1:0]               o_rms_r;
  logic                          o_ovf_r;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign sum_mag  = q_head.sum[SUM_W-1] ? SUM_W'(-q_head.sum) : SUM_W'(q_head.sum);
  assign div_end  = (step_r == STEP_W'(SQ_W - 1));
  assign root_end = (step_r == STEP_W'(RT_W - 1));
  assign load     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // One quotient bit per cycle for the sum and the sum of squares together.
  always_comb begin
    rem_a_t   = {rem_a_r[CNT_W-1:0], dvd_a_r[SQ_W-1]};
    rem_b_t   = {rem_b_r[CNT_W-1:0], dvd_b_r[SQ_W-1]};
    ge_a      = rem_a_t >= {1'b0, rec_r.count};
    ge_b      = rem_b_t >= {1'b0, rec_r.count};
    rem_a_nxt = ge_a ? rem_a_t - {1'b0, rec_r.count} : rem_a_t;
    rem_b_nxt = ge_b ? rem_b_t - {1'b0, rec_r.count} : rem_b_t;
    dvd_a_nxt = {dvd_a_r[SQ_W-2:0], ge_a};
    dvd_b_nxt = {dvd_b_r[SQ_W-2:0], ge_b};
  end

  // One root bit per cycle, two radicand bits consumed.
  always_comb begin
    rr_t      = {rrem_r, rad_r[2*RT_W-1 -: 2]};
    trial     = (RT_W+3)'({root_r, 2'b01});
    ge_r      = rr_t >= trial;
    rrem_full = ge_r ? rr_t - trial : rr_t;
    root_nxt  = {root_r[RT_W-2:0], ge_r};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_head.count == '0) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_end) begin
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (root_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        rec_r   <= q_head;
        dvd_a_r <= SQ_W'(sum_mag);
        dvd_b_r <= q_head.sq;
        rem_a_r <= '0;
        rem_b_r <= '0;
        step_r  <= '0;
      end
      ST_DIV: begin
        dvd_a_r <= dvd_a_nxt;
        dvd_b_r <= dvd_b_nxt;
        rem_a_r <= rem_a_nxt;
        rem_b_r <= rem_b_nxt;
        if (div_end) begin
          step_r <= '0;
          rad_r  <= (2*RT_W)'(dvd_b_nxt[MSQ_W-1:0]);
          root_r <= '0;
          rrem_r <= '0;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end
      ST_ROOT: begin
        rad_r  <= {rad_r[2*RT_W-3:0], 2'b00};
        root_r <= root_nxt;
        rrem_r <= rrem_full[RT_W:0];
        step_r <= step_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Truncate the mean toward zero: divide the magnitude, restore the sign.
  always_comb begin
    has      = (rec_r.count != '0);
    q_mean   = dvd_a_r[SAMPLE_BITS-1:0];
    mean_val = rec_r.sum[SUM_W-1] ? {SAMPLE_BITS{1'b0}} - q_mean : q_mean;
    out_valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_res_r  <= has;
      o_ch_r   <= has ? rec_r.ch : '0;
      o_cnt_r  <= rec_r.count;
      o_min_r  <= has ? rec_r.min_v : '0;
      o_max_r  <= has ? rec_r.max_v : '0;
      o_p2p_r  <= has ? SAMPLE_BITS'(rec_r.max_v - rec_r.min_v) : '0;
      o_dur_r  <= has ? rec_r.last_t - rec_r.first_t : '0;
      o_mean_r <= has ? signed'(mean_val) : '0;
      o_rms_r  <= has ? root_r : '0;
      o_ovf_r  <= has && rec_r.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.valid_res    = o_res_r;
  assign out_ch.channel_echo = o_ch_r;
  assign out_ch.sample_count = o_cnt_r;
  assign out_ch.min_value    = o_min_r;
  assign out_ch.max_value    = o_max_r;
  assign out_ch.peak_to_peak = o_p2p_r;
  assign out_ch.duration     = o_dur_r;
  assign out_ch.mean_value   = o_mean_r;
  assign out_ch.rms_value    = o_rms_r;
  assign out_ch.overflow     = o_ovf_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rec_r.count != '0))
    else $error("divide started with zero sample count");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result word raised outside the done state");

endmodule

>>> rtl/core/window_sample_statistics.sv
// Top level of the windowed min/max/mean/rms statistics block for one channel.
//
// Samples of one channel stream in on in_ch, one word per clock, each with a
// timestamp and a last-sample mark. Samples whose time falls in the closed
// window set by window_begin/window_end (the bounds are swapped if given in
// reverse) update count, min, max, sum, sum of squares and the first and last
// in-window times; in-window samples past MAX_SAMPLES are dropped and raise the
// overflow flag. The word carrying the last-sample mark closes the record, and
// one result word per record leaves on out_ch: count, min, max, peak-to-peak,
// duration, mean truncated toward zero and the floor square root of the
// truncated mean square. A record with no in-window sample gives an all-zero
// result word. Timing: the front takes one sample word per cycle, through a sample
// register into the accumulators, as long as the two-entry record queue has
// room. Per record the back captures it, runs the bit-serial divides of sum
// and sum of squares side by side and the bit-serial square root, then loads
// the result register; an empty record skips divide and root. Records that
// arrive faster than the back ends them throttle input once the queue fills.
// Configuration registers: index 0 window_begin, 1 window_end, 2 channel_id;
// writes to other indexes are dropped. Write them only while the block is idle.
module window_sample_statistics (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [wss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wss_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  wss_in_if.sink                           in_ch,
  wss_out_if.source                        out_ch
);
  import wss_pkg::*;

  logic [TIME_W-1:0] win_begin_r;
  logic [TIME_W-1:0] win_end_r;
  logic [CH_W-1:0]   chan_r;

  q_wr_t             q_wr;
  logic              q_valid;
  logic              q_pop;
  rec_t              q_head;
  logic [QCNT_W-1:0] q_count;

  // Configuration registers; unknown indexes fall through the default arm.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_begin_r <= '0;
      win_end_r   <= '1;
      chan_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_BEGIN: win_begin_r <= cfg_wdata[TIME_W-1:0];
        CFG_WIN_END:   win_end_r   <= cfg_wdata[TIME_W-1:0];
        CFG_CHANNEL:   chan_r      <= cfg_wdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: window test and accumulation, hands finished records to the queue.
  wss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_begin (win_begin_r),
    .win_end   (win_end_r),
    .chan      (chan_r),
    .q_count   (q_count),
    .q_wr      (q_wr),
    .in_ch     (in_ch)
  );

  // Decouple sample intake from the slow per-record arithmetic.
  wss_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .pop     (q_pop),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_count (q_count)
  );

  // Back: divide, square root, result register.
  wss_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
